@@ design/qpn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpn_pkg
// Shared widths, command codes and word types for the quaternion product and
// normalize pipeline.
// ----------------------------------------------------------------------------
package qpn_pkg;

  // Component format, fixed by the port words
  localparam int CW           = 16;
  localparam int FRAC_DEFAULT = 14;

  // Normalized components lie below 2^NORM_TOP
  localparam int NORM_TOP = 30;
  localparam int UW       = NORM_TOP;
  localparam int SQW      = 2 * UW + 2;   // sum of four squares
  localparam int RTW      = UW + 1;       // floor square root

  typedef enum logic [1:0] {
    CMD_NORM_AB = 2'd0,
    CMD_PROD_BA = 2'd1,
    CMD_NORM_A  = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]           command;
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] a_w;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic signed [CW-1:0] b_w;
  } in_word_t;

  typedef struct packed {
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [CW-1:0] r_z;
    logic signed [CW-1:0] r_w;
    logic                 zero_magnitude;
    logic                 saturated;
  } out_word_t;

  // Partial root and remainder handed along the root cells
  typedef struct packed {
    logic [RTW-1:0] root;
    logic [SQW-1:0] rem;
  } sqrt_t;

endpackage

@@ design/quaternion_product_normalize.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_product_normalize
// Hamilton product of two Q2.14 quaternions, optionally scaled to unit length, or a alone
// scaled to unit length, through a chain of square root cells and divide cells.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | word
//  in      | input     | in_valid_i / in_stall_o | in_word_t
//  out     | output    | out_valid_o/out_stall_i | out_word_t
//
//  One word per cycle while the skid register is empty. A word reaches
//  out_valid_o through 7 product and scaling stages, 31 root cells,
//  one dividend stage, FRACTION_BITS + 1 divide cells and the output register.
//  A skid register behind the output takes one word while out_stall_i holds;
//  the pipeline stops only while the skid register is full.
//  Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module quaternion_product_normalize #(
  parameter int FRACTION_BITS = qpn_pkg::FRAC_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  qpn_pkg::in_word_t in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output qpn_pkg::out_word_t out_word_o
);
  import qpn_pkg::*;

  localparam int PW   = 2 * CW;
  localparam int SW   = 2 * CW + 2;
  localparam int MW   = 2 * CW + 1;
  localparam int PSW  = $clog2(MW);
  localparam int QW   = FRACTION_BITS + 1;
  localparam int NW   = UW + FRACTION_BITS + 1;
  localparam int NST  = 6 + 1 + RTW + 1 + QW;
  localparam int EW   = (MW + 1 > QW) ? MW + 1 : QW;
  localparam logic [EW-1:0] HALF = EW'(1) << (CW - 1);

  // Term sign per component (bit c*4+k)
  localparam logic [15:0] NEG_MASK = 16'b1110_0100_0010_1000;
  localparam logic [1:0] PIDX [4][4] = '{'{2'd3, 2'd0, 2'd1, 2'd2},
                                          '{2'd3, 2'd0, 2'd1, 2'd2},
                                          '{2'd3, 2'd0, 2'd1, 2'd2},
                                          '{2'd3, 2'd0, 2'd1, 2'd2}};
  localparam logic [1:0] QIDX [4][4] = '{'{2'd0, 2'd3, 2'd2, 2'd1},
                                          '{2'd1, 2'd2, 2'd3, 2'd0},
                                          '{2'd2, 2'd1, 2'd0, 2'd3},
                                          '{2'd3, 2'd0, 2'd1, 2'd2}};

  typedef struct packed {
    logic [1:0]         cmd;
    logic [3:0]         neg;
    logic               zero;
    logic [3:0][CW-1:0] pr;
    logic               psat;
  } side_t;

  // Clamp a magnitude and apply the sign; returns {sat, value}
  function automatic logic [CW:0] emit(input logic neg, input logic [EW-1:0] mag);
    logic [EW-1:0] lim;
    logic [EW-1:0] m;
    logic          s;
    lim = neg ? HALF : HALF - EW'(1);
    s   = mag > lim;
    m   = s ? lim : mag;
    return {s, CW'(neg ? (~m + EW'(1)) : m)};
  endfunction

  logic adv;
  logic [NST-1:0] vld_q;

  // ---- stage 1: products
  logic signed [CW-1:0] av [4];
  logic signed [CW-1:0] bv [4];
  logic signed [CW-1:0] pv [4];
  logic signed [CW-1:0] qv [4];
  logic signed [PW-1:0] t1_d [4][4];
  logic signed [PW-1:0] t1_q [4][4];
  logic [1:0]           cmd1_q;

  always_comb begin
    av[0] = in_word_i.a_x; av[1] = in_word_i.a_y;
    av[2] = in_word_i.a_z; av[3] = in_word_i.a_w;
    bv[0] = in_word_i.b_x; bv[1] = in_word_i.b_y;
    bv[2] = in_word_i.b_z; bv[3] = in_word_i.b_w;
    for (int i = 0; i < 4; i++) begin
      pv[i] = (in_word_i.command == CMD_PROD_BA) ? bv[i] : av[i];
      qv[i] = (in_word_i.command == CMD_PROD_BA) ? av[i] : bv[i];
    end
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        if (in_word_i.command == CMD_NORM_A) begin
          t1_d[c][k] = (k == 0) ? PW'(av[c]) : '0;
        end else begin
          t1_d[c][k] = pv[PIDX[c][k]] * qv[QIDX[c][k]];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_q   <= t1_d;
      cmd1_q <= in_word_i.command;
    end
  end

  // ---- stage 2: exact sums as sign and magnitude
  logic signed [SW-1:0] s2 [4];
  logic [3:0][MW-1:0]   mag2_q;
  logic [3:0]           neg2_q;
  logic [1:0]           cmd2_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      s2[c] = '0;
      for (int k = 0; k < 4; k++) begin
        if (NEG_MASK[c*4+k]) s2[c] = s2[c] - SW'(t1_q[c][k]);
        else                 s2[c] = s2[c] + SW'(t1_q[c][k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        neg2_q[c] <= s2[c][SW-1];
        mag2_q[c] <= s2[c][SW-1] ? MW'(-s2[c]) : MW'(s2[c]);
      end
      cmd2_q <= cmd1_q;
    end
  end

  // ---- stage 3: rounded plain product, OR of magnitudes
  side_t              side3_d, side3_q;
  logic [3:0][MW-1:0] mag3_q;
  logic [MW-1:0]      orr3_q;
  logic [EW-1:0]      rq3;
  logic [CW:0]        em3;

  always_comb begin
    side3_d      = '0;
    side3_d.cmd  = cmd2_q;
    side3_d.neg  = neg2_q;
    for (int c = 0; c < 4; c++) begin
      rq3 = EW'(mag2_q[c] >> FRACTION_BITS) + EW'(mag2_q[c][FRACTION_BITS-1]);
      em3 = emit(neg2_q[c] && (rq3 != '0), rq3);
      side3_d.pr[c] = em3[CW-1:0];
      side3_d.psat  = side3_d.psat | em3[CW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side3_q <= side3_d;
      mag3_q  <= mag2_q;
      orr3_q  <= mag2_q[0] | mag2_q[1] | mag2_q[2] | mag2_q[3];
    end
  end

  // ---- stage 4: leading one position of the largest magnitude
  logic [PSW-1:0]     pos4_d, pos4_q;
  side_t              side4_d, side4_q;
  logic [3:0][MW-1:0] mag4_q;

  always_comb begin
    pos4_d = '0;
    for (int i = 0; i < MW; i++) begin
      if (orr3_q[i]) pos4_d = PSW'(i);
    end
    side4_d      = side3_q;
    side4_d.zero = (orr3_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side4_q <= side4_d;
      mag4_q  <= mag3_q;
      pos4_q  <= pos4_d;
    end
  end

  // ---- stage 5: common shift so the largest lies in [2^29, 2^30)
  logic [3:0][UW-1:0] u5_d, u5_q;
  side_t              side5_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (pos4_q >= PSW'(UW - 1)) u5_d[c] = UW'(mag4_q[c] >> (pos4_q - PSW'(UW - 1)));
      else                        u5_d[c] = UW'(mag4_q[c] << (PSW'(UW - 1) - pos4_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      u5_q    <= u5_d;
      side5_q <= side4_q;
    end
  end

  // ---- stage 6: squares
  logic [3:0][2*UW-1:0] sq6_q;
  logic [3:0][UW-1:0]   u6_q;
  side_t                side6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) sq6_q[c] <= u5_q[c] * u5_q[c];
      u6_q    <= u5_q;
      side6_q <= side5_q;
    end
  end

  // ---- stage 7 and root cells
  sqrt_t              sq_st      [RTW+1];
  side_t              sqs_side_q [RTW+1];
  logic [3:0][UW-1:0] sqs_u_q    [RTW+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_st[0].root <= '0;
      sq_st[0].rem  <= SQW'(sq6_q[0]) + SQW'(sq6_q[1]) + SQW'(sq6_q[2]) + SQW'(sq6_q[3]);
      sqs_side_q[0] <= side6_q;
      sqs_u_q[0]    <= u6_q;
    end
  end

  for (genvar j = 0; j < RTW; j++) begin : g_sqrt
    qpn_sqrt_cell #(.K(RTW - 1 - j)) u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .st_i  (sq_st[j]),
      .st_o  (sq_st[j+1])
    );
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sqs_side_q[j+1] <= sqs_side_q[j];
        sqs_u_q[j+1]    <= sqs_u_q[j];
      end
    end
  end

  // ---- dividend stage and divide cells
  logic [RTW-1:0]     dv_m     [QW+1];
  logic [3:0][NW-1:0] dv_rem   [QW+1];
  logic [3:0][QW-1:0] dv_quo   [QW+1];
  side_t              dv_side_q[QW+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_m[0]      <= sq_st[RTW].root;
      dv_quo[0]    <= '0;
      dv_side_q[0] <= sqs_side_q[RTW];
      for (int c = 0; c < 4; c++) begin
        dv_rem[0][c] <= (NW'(sqs_u_q[RTW][c]) << FRACTION_BITS)
                      + NW'(sq_st[RTW].root >> 1);
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    qpn_div_cell #(.K(QW - 1 - j), .NW(NW), .QW(QW)) u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .m_i   (dv_m[j]),
      .rem_i (dv_rem[j]),
      .quo_i (dv_quo[j]),
      .m_o   (dv_m[j+1]),
      .rem_o (dv_rem[j+1]),
      .quo_o (dv_quo[j+1])
    );
    always_ff @(posedge clk_i) begin
      if (adv) dv_side_q[j+1] <= dv_side_q[j];
    end
  end

  // ---- result word from the last stage
  out_word_t          res;
  side_t              fs;
  logic [3:0][CW-1:0] rc;
  logic               rsat;
  logic [CW:0]        emf;

  always_comb begin
    fs   = dv_side_q[QW];
    rc   = '0;
    rsat = 1'b0;
    res  = '0;
    emf  = '0;
    case (fs.cmd)
      CMD_PROD_BA: begin
        rc   = fs.pr;
        rsat = fs.psat;
      end
      CMD_NORM_AB, CMD_NORM_A: begin
        if (!fs.zero) begin
          for (int c = 0; c < 4; c++) begin
            emf   = emit(fs.neg[c] && (dv_quo[QW][c] != '0), EW'(dv_quo[QW][c]));
            rc[c] = emf[CW-1:0];
            rsat  = rsat | emf[CW];
          end
        end
        res.zero_magnitude = fs.zero;
      end
      default: begin
        rc = '0;
      end
    endcase
    res.r_x       = rc[0];
    res.r_y       = rc[1];
    res.r_z       = rc[2];
    res.r_w       = rc[3];
    res.saturated = rsat;
  end

  // ---- valid line, output register and skid register
  logic      out_v_q, skid_v_q;
  out_word_t out_q, skid_q;
  logic      res_v;

  assign adv        = !skid_v_q;
  assign in_stall_o = skid_v_q;
  assign res_v      = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (adv) vld_q <= {vld_q[NST-2:0], in_valid_i};
      if (!out_v_q || !out_stall_i) begin
        if (skid_v_q) begin
          out_v_q  <= 1'b1;
          skid_v_q <= 1'b0;
        end else begin
          out_v_q <= res_v;
        end
      end else if (res_v && !skid_v_q) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || !out_stall_i) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (res_v && !skid_v_q) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

  // ---- assertions
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid word held without an output word");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && out_stall_i))
    else $error("skid filled while output was free");

  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.zero_magnitude) |->
      (out_word_o.r_x == '0 && out_word_o.r_y == '0 && out_word_o.r_z == '0 &&
       out_word_o.r_w == '0 && !out_word_o.saturated))
    else $error("zero magnitude word carries data");

endmodule

@@ design/qpn_sqrt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpn_sqrt_cell
// One restoring square root cell: decides root bit K and passes the partial
// root and remainder to the next cell.
// ----------------------------------------------------------------------------
module qpn_sqrt_cell #(
  parameter int K = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  qpn_pkg::sqrt_t st_i,
  output qpn_pkg::sqrt_t st_o
);
  import qpn_pkg::*;

  localparam int DW = SQW + 1;

  logic [DW-1:0] delta;
  logic [DW-1:0] rem_x;
  sqrt_t         st_d;
  sqrt_t         st_q;

  // (root + 2^K)^2 - root^2, root holds only bits above K
  always_comb begin
    delta = (DW'(st_i.root) << (K + 1)) | (DW'(1) << (2 * K));
    rem_x = DW'(st_i.rem);
    st_d  = st_i;
    if (rem_x >= delta) begin
      st_d.rem  = SQW'(rem_x - delta);
      st_d.root = st_i.root | (RTW'(1) << K);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;

endmodule

@@ design/qpn_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpn_div_cell
// One restoring divide cell for four lanes sharing a divisor: decides
// quotient bit K of each lane and passes the remainders on.
// ----------------------------------------------------------------------------
module qpn_div_cell #(
  parameter int K  = 0,
  parameter int NW = 45,
  parameter int QW = 15
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [qpn_pkg::RTW-1:0]   m_i,
  input  logic [3:0][NW-1:0]        rem_i,
  input  logic [3:0][QW-1:0]        quo_i,
  output logic [qpn_pkg::RTW-1:0]   m_o,
  output logic [3:0][NW-1:0]        rem_o,
  output logic [3:0][QW-1:0]        quo_o
);
  import qpn_pkg::*;

  logic [NW:0]          dv;
  logic [3:0][NW-1:0]   rem_d;
  logic [3:0][QW-1:0]   quo_d;
  logic [RTW-1:0]       m_q;
  logic [3:0][NW-1:0]   rem_q;
  logic [3:0][QW-1:0]   quo_q;

  // Trial subtract of m * 2^K in each lane
  always_comb begin
    dv = (NW'(m_i) << K);
    for (int l = 0; l < 4; l++) begin
      rem_d[l] = rem_i[l];
      quo_d[l] = quo_i[l];
      if ({1'b0, rem_i[l]} >= dv) begin
        rem_d[l] = NW'({1'b0, rem_i[l]} - dv);
        quo_d[l] = quo_i[l] | (QW'(1) << K);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q   <= m_i;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign m_o   = m_q;
  assign rem_o = rem_q;
  assign quo_o = quo_q;

endmodule

@@ test/quaternion_product_normalize_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_product_normalize_tb
// Drives command and quaternion words with random gaps and output stalls,
// predicts each result word in the bench and checks every field in order.
// ----------------------------------------------------------------------------
module quaternion_product_normalize_tb;
  import qpn_pkg::*;

  localparam int FB        = FRAC_DEFAULT;
  localparam int LATENCY   = 41 + FB;
  localparam int N_RANDOM  = 1950;
  localparam int STALL_MAX = 16;
  localparam int WD_LIMIT  = 4000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  quaternion_product_normalize #(.FRACTION_BITS(FB)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  int        errors;
  int        idle_cycles;
  bit        stim_done;

  // Signed sum in sign-magnitude form, wide enough for four Q4.28 products
  typedef struct {
    bit       neg;
    bit [63:0] mag;
  } smag_t;

  function automatic smag_t to_smag(longint v);
    smag_t s;
    s.neg = v < 0;
    s.mag = (v < 0) ? 64'(-v) : 64'(v);
    return s;
  endfunction

  // Component of a Hamilton product p*q: index 0..3 = x, y, z, w
  function automatic longint ham_comp(longint p[4], longint q[4], int k);
    case (k)
      0: return p[3]*q[0] + p[0]*q[3] + p[1]*q[2] - p[2]*q[1];
      1: return p[3]*q[1] - p[0]*q[2] + p[1]*q[3] + p[2]*q[0];
      2: return p[3]*q[2] + p[0]*q[1] - p[1]*q[0] + p[2]*q[3];
      default: return p[3]*q[3] - p[0]*q[0] - p[1]*q[1] - p[2]*q[2];
    endcase
  endfunction

  // Clamp a sign-magnitude value to a component
  function automatic logic [CW-1:0] clamp_comp(bit neg, bit [63:0] mag, ref bit sat);
    bit [63:0] lim;
    lim = neg ? (64'd1 << (CW-1)) : ((64'd1 << (CW-1)) - 1);
    if (mag > lim) begin
      mag = lim;
      sat = 1'b1;
    end
    return neg ? CW'(-mag) : CW'(mag);
  endfunction

  function automatic bit [63:0] floor_sqrt(bit [63:0] x);
    bit [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  // Scale to unit length; returns 1 for a zero quaternion
  function automatic bit unit_scale(smag_t v[4], ref logic [CW-1:0] r[4], ref bit sat);
    bit [63:0] u[4];
    bit [63:0] mx, sumsq, m, q;
    int rs, ls;
    mx = 0; sumsq = 0; rs = 0; ls = 0;
    for (int i = 0; i < 4; i++) begin
      u[i] = v[i].mag;
      if (u[i] > mx) mx = u[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 4; i++) r[i] = '0;
      return 1'b1;
    end
    while ((mx >> rs) >= (64'd1 << NORM_TOP)) rs++;
    while ((mx << ls) < (64'd1 << (NORM_TOP-1))) ls++;
    for (int i = 0; i < 4; i++) begin
      u[i] = (u[i] >> rs) << ls;
      sumsq += u[i] * u[i];
    end
    m = floor_sqrt(sumsq);
    for (int i = 0; i < 4; i++) begin
      q = ((u[i] << FB) + (m >> 1)) / m;
      r[i] = clamp_comp(v[i].neg && q != 0, q, sat);
    end
    return 1'b0;
  endfunction

  function automatic out_word_t predict_result(in_word_t w);
    out_word_t o;
    longint a[4], b[4];
    smag_t v[4];
    logic [CW-1:0] r[4];
    bit zero, sat;
    bit [63:0] q;
    zero = 0; sat = 0;
    a = '{longint'(w.a_x), longint'(w.a_y), longint'(w.a_z), longint'(w.a_w)};
    b = '{longint'(w.b_x), longint'(w.b_y), longint'(w.b_z), longint'(w.b_w)};
    for (int i = 0; i < 4; i++) r[i] = '0;
    case (cmd_e'(w.command))
      CMD_NORM_AB: begin
        for (int i = 0; i < 4; i++) v[i] = to_smag(ham_comp(a, b, i));
        zero = unit_scale(v, r, sat);
      end
      CMD_PROD_BA: begin
        for (int i = 0; i < 4; i++) begin
          v[i] = to_smag(ham_comp(b, a, i));
          q = (v[i].mag >> FB) + ((v[i].mag >> (FB-1)) & 64'd1);
          r[i] = clamp_comp(v[i].neg && q != 0, q, sat);
        end
      end
      CMD_NORM_A: begin
        for (int i = 0; i < 4; i++) v[i] = to_smag(a[i]);
        zero = unit_scale(v, r, sat);
      end
      default: ;
    endcase
    o.r_x = r[0]; o.r_y = r[1]; o.r_z = r[2]; o.r_w = r[3];
    o.zero_magnitude = zero;
    o.saturated = sat;
    return o;
  endfunction

  function automatic logic [CW-1:0] rand_comp();
    case ($urandom_range(0, 7))
      0: return CW'(16'h8000);
      1: return CW'(16'h7fff);
      2: return '0;
      3: return CW'($urandom_range(0, 1) ? 16'h4000 : 16'hc000);
      4: return CW'($urandom_range(0, 63)) - CW'(32);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic in_word_t make_word(logic [1:0] cmd, logic [CW-1:0] v[8]);
    in_word_t w;
    w.command = cmd;
    w.a_x = v[0]; w.a_y = v[1]; w.a_z = v[2]; w.a_w = v[3];
    w.b_x = v[4]; w.b_y = v[5]; w.b_z = v[6]; w.b_w = v[7];
    return w;
  endfunction

  // Clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Stimulus: directed corners, then random words
  initial begin
    logic [CW-1:0] v[8];
    logic [CW-1:0] corner[4];
    corner = '{CW'(16'h8000), CW'(16'h7fff), CW'(16'h0000), CW'(16'h4000)};
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 8; k++) v[k] = '0;
      pending_words.push_back(make_word(2'(c), v));           // zero magnitude
      for (int k = 0; k < 8; k++) v[k] = CW'(16'h8000);
      pending_words.push_back(make_word(2'(c), v));           // all most negative
      for (int k = 0; k < 8; k++) v[k] = CW'(16'h7fff);
      pending_words.push_back(make_word(2'(c), v));           // all most positive
      for (int k = 0; k < 8; k++) v[k] = corner[(k + c) % 4];
      pending_words.push_back(make_word(2'(c), v));
      for (int k = 0; k < 8; k++) v[k] = (k == 3 || k == 7) ? CW'(16'h4000) : '0;
      pending_words.push_back(make_word(2'(c), v));           // unit quaternions
      for (int k = 0; k < 8; k++) v[k] = (k == c) ? CW'(1) : CW'(16'hffff);
      pending_words.push_back(make_word(2'(c), v));           // tiny magnitudes
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      for (int k = 0; k < 8; k++) v[k] = rand_comp();
      pending_words.push_back(make_word($urandom_range(0, 9) == 0 ? CMD_NONE :
                                        2'($urandom_range(0, 2)), v));
    end
    stim_done = 1'b1;
  end

  // Driver
  int in_gap;
  initial begin
    in_valid_i = 1'b0;
    in_word_i = '0;
    in_gap = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_words.push_back(predict_result(in_word_i));
        in_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, STALL_MAX);
        if ($urandom_range(0, 1)) in_gap = 0;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_valid_i <= 1'b1;
          in_word_i <= pending_words.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor and output stalls
  int out_hold;
  initial begin
    out_stall_i = 1'b1;
    out_hold = 0;
    errors = 0;
  end

  always @(posedge clk_i) begin
    out_word_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          e = expected_words.pop_front();
          if (out_word_o.r_x !== e.r_x) begin
            $error("r_x expected %0d got %0d", e.r_x, out_word_o.r_x); errors++;
          end
          if (out_word_o.r_y !== e.r_y) begin
            $error("r_y expected %0d got %0d", e.r_y, out_word_o.r_y); errors++;
          end
          if (out_word_o.r_z !== e.r_z) begin
            $error("r_z expected %0d got %0d", e.r_z, out_word_o.r_z); errors++;
          end
          if (out_word_o.r_w !== e.r_w) begin
            $error("r_w expected %0d got %0d", e.r_w, out_word_o.r_w); errors++;
          end
          if (out_word_o.zero_magnitude !== e.zero_magnitude) begin
            $error("zero_magnitude expected %0b got %0b",
                   e.zero_magnitude, out_word_o.zero_magnitude);
            errors++;
          end
          if (out_word_o.saturated !== e.saturated) begin
            $error("saturated expected %0b got %0b", e.saturated, out_word_o.saturated);
            errors++;
          end
        end
        // new stall length per word; half the time none
        out_hold = $urandom_range(0, 1) ? 0 : $urandom_range(0, STALL_MAX);
      end
      if (out_hold > 0) begin
        out_hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: cycles with no word accepted on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // End of run; queues and counters are sampled away from the active edge
  initial begin
    idle_cycles = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    while (!(stim_done && pending_words.size() == 0 && !in_valid_i &&
             expected_words.size() == 0) && idle_cycles < WD_LIMIT)
      @(negedge clk_i);
    if (idle_cycles >= WD_LIMIT) begin
      $display("quaternion_product_normalize: mismatch");
    end else begin
      repeat (LATENCY + 20) @(posedge clk_i);
      if (errors == 0)
        $display("quaternion_product_normalize: match");
      else
        $display("quaternion_product_normalize: mismatch");
    end
    $finish;
  end

endmodule
